// File: hw/rtl/base64_stream_codec_core_macros.svh
// Assertion macros used by the codec RTL; b64c_back.sv includes them.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

// Property that must hold whenever the block is out of reset.
`define B64C_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("b64c assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define B64C_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64c assertion failed");

`endif

// File: hw/rtl/b64c_pkg.sv
// Package for the base64 stream codec: constants, the job type and alphabet functions.
// No dependencies; every other .sv RTL file uses it.
`default_nettype none

package b64c_pkg;

  localparam int unsigned CfgIdxW       = 8;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [CfgIdxW-1:0] CfgMode      = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgPrintable = CfgIdxW'(1);

  localparam logic [7:0] PadChar      = 8'h3D;
  localparam logic [7:0] PrintableLow = 8'd32;
  localparam logic [7:0] PrintableHi  = 8'd126;

  localparam logic ModeEncode = 1'b0;

  typedef struct packed {
    logic        mode;
    logic        status;
    logic        bad;
    logic        eom;
    logic [1:0]  nout_m1;
    logic [2:0]  nalpha;
    logic [23:0] value;
  } b64c_job_t;

  function automatic logic [7:0] b64c_char(input logic [5:0] s);
    logic [7:0] r;
    if (s < 6'd26) begin
      r = 8'h41 + {2'b00, s};
    end else if (s < 6'd52) begin
      r = 8'h61 + {2'b00, s} - 8'd26;
    end else if (s < 6'd62) begin
      r = 8'h30 + {2'b00, s} - 8'd52;
    end else if (s == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Bit 6 set means the character is outside the alphabet.
  function automatic logic [6:0] b64c_sextet(input logic [7:0] c);
    logic [6:0] r;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      r = 7'd62;
    end else if (c == 8'h2F) begin
      r = 7'd63;
    end else begin
      r = 7'd64;
    end
    return r;
  endfunction

  function automatic logic [2:0] b64c_dec_bytes(input logic [2:0] data);
    return (data > 3'd1) ? 3'(data - 3'd1) : 3'd0;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b64c_ifs.sv
// Handshake interfaces for the input, result and configuration channels.
// Depends on b64c_pkg for the configuration index width.
`default_nettype none

interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_char;
  logic       message_end;
  modport source (output valid, output data_char, output message_end, input ready);
  modport sink (input valid, input data_char, input message_end, output ready);
endinterface

interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       bad_input;
  logic       run_last;
  logic       message_last;
  modport source (output valid, output out_char, output char_valid, output bad_input,
                  output run_last, output message_last, input ready);
  modport sink (input valid, input out_char, input char_valid, input bad_input,
                input run_last, input message_last, output ready);
endinterface

interface b64c_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [b64c_pkg::CfgIdxW-1:0] index;
  logic                        data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/base64_stream_codec_core.sv
// Top level of the base64 stream codec: front end, job queue and result sequencer.
// Depends on b64c_pkg, the channel interfaces, b64c_front, b64c_fifo and b64c_back.
//
//   channel  modport  beat
//   in_i     sink     data_char, message_end
//   out_o    source   out_char, char_valid, bad_input, run_last, message_last
//   cfg_i    sink     index (0 mode, 1 printable_only), data
//
// The front end takes one item per cycle while the job queue has room.
// Results leave at one per cycle while out_o.ready does not stall: an item gives
// zero to four beats, so the single port limits encoding to 3 bytes per 4 beats.
// An item's first beat passes the job queue, job register and output register.
// Reset clears all control state at once; there is no clearing pass.
// A stalled result port fills the queue, then drops in_i.ready.
`default_nettype none

module base64_stream_codec_core #(
  parameter int unsigned QueueDepth = b64c_pkg::QueueDepthDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  b64c_in_if.sink   in_i,
  b64c_out_if.source out_o,
  b64c_cfg_if.sink  cfg_i
);
  import b64c_pkg::*;

  b64c_job_t push_job, pop_job;
  logic      push, full, q_valid, pop;

  b64c_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .full_i (full),
    .push_o (push),
    .job_o  (push_job)
  );

  b64c_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (pop_job)
  );

  b64c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .job_i   (pop_job),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/b64c_front.sv
// Front end: holds the registers and the partial group, classifies each item into a job.
// Depends on b64c_pkg and the channel interfaces.
`default_nettype none

module b64c_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  b64c_in_if.sink              in_i,
  b64c_cfg_if.sink             cfg_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output b64c_pkg::b64c_job_t  job_o
);
  import b64c_pkg::*;

  logic        mode_q, printable_q;
  logic [17:0] gb_q, gb_d;
  logic [1:0]  gc_q, gc_d;
  logic [1:0]  pc_q, pc_d;
  logic        accept, bad, is_pad, need;
  logic [7:0]  c;
  logic [6:0]  sx;
  logic [5:0]  sv;
  logic [2:0]  nres, data;
  logic [23:0] v;
  logic [2:0]  nalpha;

  assign c        = in_i.data_char;
  assign in_i.ready = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept   = in_i.valid && in_i.ready;

  always_comb begin
    gb_d   = gb_q;
    gc_d   = gc_q;
    pc_d   = pc_q;
    nres   = 3'd0;
    nalpha = 3'd4;
    v      = '0;
    bad    = 1'b0;
    data   = 3'd0;
    is_pad = (c == PadChar);
    sx     = b64c_sextet(c);
    sv     = is_pad ? 6'd0 : sx[5:0];
    if (mode_q == ModeEncode) begin
      bad = printable_q && (c < PrintableLow || c > PrintableHi);
      if (!bad) begin
        if (gc_q[1]) begin
          v    = {gb_q[15:0], c};
          nres = 3'd4;
          gb_d = '0;
          gc_d = '0;
          pc_d = '0;
        end else begin
          gb_d = {2'b00, gb_q[7:0], c};
          gc_d = 2'(gc_q + 2'd1);
        end
      end
      if (in_i.message_end && gc_d != 2'd0) begin
        if (gc_d == 2'd1) begin
          v      = {gb_d[7:0], 16'h0000};
          nalpha = 3'd2;
        end else begin
          v      = {gb_d[15:0], 8'h00};
          nalpha = 3'd3;
        end
        nres = 3'd4;
      end
    end else begin
      bad = !is_pad && (sx[6] || pc_q != 2'd0);
      if (!bad) begin
        if (gc_q == 2'd3) begin
          v    = {gb_q, sv};
          data = 3'(3'd4 - {1'b0, pc_q} - {2'b00, is_pad});
          nres = b64c_dec_bytes(data);
          gb_d = '0;
          gc_d = '0;
          pc_d = '0;
        end else begin
          gb_d = {gb_q[11:0], sv};
          gc_d = 2'(gc_q + 2'd1);
          pc_d = 2'(pc_q + {1'b0, is_pad});
        end
      end
      if (in_i.message_end && gc_d != 2'd0) begin
        unique case (gc_d)
          2'd1:    v = {gb_d[5:0], 18'h00000};
          2'd2:    v = {gb_d[11:0], 12'h000};
          default: v = {gb_d, 6'h00};
        endcase
        data = 3'({1'b0, gc_d} - {1'b0, pc_d});
        nres = b64c_dec_bytes(data);
      end
    end
    if (in_i.message_end) begin
      gb_d = '0;
      gc_d = '0;
      pc_d = '0;
    end
  end

  assign need   = (nres != 3'd0) || bad || in_i.message_end;
  assign push_o = accept && need;

  always_comb begin
    job_o.mode    = mode_q;
    job_o.status  = (nres == 3'd0);
    job_o.bad     = bad;
    job_o.eom     = in_i.message_end;
    job_o.nout_m1 = (nres == 3'd0) ? 2'd0 : 2'(nres - 3'd1);
    job_o.nalpha  = nalpha;
    job_o.value   = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeEncode;
      printable_q <= 1'b1;
      gb_q        <= '0;
      gc_q        <= '0;
      pc_q        <= '0;
    end else if (cfg_i.valid && cfg_i.index == CfgMode) begin
      mode_q <= cfg_i.data;
      gb_q   <= '0;
      gc_q   <= '0;
      pc_q   <= '0;
    end else if (cfg_i.valid && cfg_i.index == CfgPrintable) begin
      printable_q <= cfg_i.data;
    end else if (accept) begin
      gb_q <= gb_d;
      gc_q <= gc_d;
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64c_fifo.sv
// Job queue between the front end and the result sequencer, first word fall through.
// Depends on b64c_pkg for the job type.
`default_nettype none

module b64c_fifo #(
  parameter int unsigned Depth = b64c_pkg::QueueDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire b64c_pkg::b64c_job_t job_i,
  output logic                     full_o,
  output logic                     valid_o,
  input  wire logic                pop_i,
  output b64c_pkg::b64c_job_t      job_o
);
  import b64c_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64c_job_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b64c_back.sv
// Result sequencer: expands one job into its result beats into an output register.
// Depends on b64c_pkg, the channel interfaces and the assertion macro header.
`default_nettype none
`include "base64_stream_codec_core_macros.svh"

module b64c_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire b64c_pkg::b64c_job_t job_i,
  output logic                     pop_o,
  b64c_out_if.source               out_o
);
  import b64c_pkg::*;

  b64c_job_t  job_q;
  logic       job_valid_q;
  logic [1:0] k_q;
  logic       out_valid_q;
  logic [7:0] char_q, char_d;
  logic       cv_q, bad_q, rl_q, ml_q;
  logic       emit, last;
  logic [5:0] sext;

  assign emit  = job_valid_q && (!out_valid_q || out_o.ready);
  assign last  = (k_q == job_q.nout_m1);
  assign pop_o = valid_i && (!job_valid_q || (emit && last));

  always_comb begin
    unique case (k_q)
      2'd0:    sext = job_q.value[23:18];
      2'd1:    sext = job_q.value[17:12];
      2'd2:    sext = job_q.value[11:6];
      default: sext = job_q.value[5:0];
    endcase
    if (job_q.status) begin
      char_d = 8'h00;
    end else if (job_q.mode != ModeEncode) begin
      unique case (k_q)
        2'd0:    char_d = job_q.value[23:16];
        2'd1:    char_d = job_q.value[15:8];
        default: char_d = job_q.value[7:0];
      endcase
    end else if ({1'b0, k_q} < job_q.nalpha) begin
      char_d = b64c_char(sext);
    end else begin
      char_d = PadChar;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        job_valid_q <= 1'b1;
        k_q         <= '0;
      end else if (emit && last) begin
        job_valid_q <= 1'b0;
      end else if (emit) begin
        k_q <= 2'(k_q + 2'd1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      char_q <= char_d;
      cv_q   <= !job_q.status;
      bad_q  <= job_q.bad;
      rl_q   <= last;
      ml_q   <= last && job_q.eom;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_char     = char_q;
  assign out_o.char_valid   = cv_q;
  assign out_o.bad_input    = bad_q;
  assign out_o.run_last     = rl_q;
  assign out_o.message_last = ml_q;

  `B64C_ASSERT(a_k_in_range, job_valid_q |-> (k_q <= job_q.nout_m1))
  `B64C_ASSERT(a_status_single, (job_valid_q && job_q.status) |-> (job_q.nout_m1 == 2'd0))
  `B64C_ASSERT_NEXT(a_run_continues, emit && !last, job_valid_q)

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for base64_stream_codec_core: encodes and decodes random and directed
// streams and checks every result beat against a cycle-free model of the codec.
// Depends on b64c_pkg, the channel interfaces in b64c_ifs.sv and the codec RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64c_pkg::*;

  localparam logic ModeDecode = ~ModeEncode;
  localparam logic [CfgIdxW-1:0] CfgPastEnd = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgIdxMax = '1;
  localparam int SettleCycles = 12;
  localparam int QuietLimit = 2000;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_ok;
    logic       bad;
    logic       run_last;
    logic       msg_last;
  } beat_t;

  typedef struct packed {
    logic [7:0] code;
    logic       eom;
  } item_t;

  logic clk = 1'b0;
  logic rst_n;

  b64c_in_if  in_if ();
  b64c_out_if out_if ();
  b64c_cfg_if cfg_if ();

  base64_stream_codec_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model state and register copies.
  logic        cur_mode = ModeEncode;
  logic        printable = 1'b1;
  logic [17:0] grp_bits = '0;
  logic [1:0]  grp_cnt = '0;
  logic [1:0]  pad_cnt = '0;

  beat_t item_beats[$];
  beat_t codec_beats_due[$];
  item_t chars_to_send[$];

  logic item_held = 1'b0;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   items_in = 0;
  int   results_seen = 0;
  int   reg_writes = 0;

  function automatic logic [7:0] glyph(input logic [5:0] s);
    if (s < 6'd26) return "A" + {2'b00, s};
    if (s < 6'd52) return "a" + {2'b00, s} - 8'd26;
    if (s < 6'd62) return "0" + {2'b00, s} - 8'd52;
    if (s == 6'd62) return "+";
    return "/";
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt = '0;
    pad_cnt = '0;
  endfunction

  function automatic void add_beat(input logic [7:0] ch, input logic ok);
    item_beats.push_back({ch, ok, 3'b000});
  endfunction

  function automatic void put_glyphs(input logic [23:0] v, input int nchars);
    int k;
    for (k = 0; k < 4; k++) begin
      add_beat((k < nchars) ? glyph(v[23-6*k -: 6]) : PadChar, 1'b1);
    end
  endfunction

  function automatic void put_bytes(input logic [23:0] v, input int data);
    int nb, k;
    nb = (data > 1) ? data - 1 : 0;
    if (nb > 3) nb = 3;
    for (k = 0; k < nb; k++) begin
      add_beat(v[23-8*k -: 8], 1'b1);
    end
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    case (idx)
      CfgMode: begin
        cur_mode = val;
        clear_group();
      end
      CfgPrintable: begin
        printable = val;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void predict_codec_beats(input logic [7:0] c, input logic eom);
    logic        bad, is_pad, known;
    logic [5:0]  sx;
    logic [23:0] v;
    int          span, k;
    beat_t       b;
    bad = 1'b0;
    is_pad = (c == PadChar);
    known = 1'b1;
    sx = '0;
    item_beats.delete();
    if (cur_mode == ModeEncode) begin
      if (printable && (c < PrintableLow || c > PrintableHi)) begin
        bad = 1'b1;
      end else if (grp_cnt >= 2'd2) begin
        put_glyphs({grp_bits[15:0], c}, 4);
        clear_group();
      end else begin
        grp_bits = {2'b00, grp_bits[7:0], c};
        grp_cnt++;
      end
      if (eom && grp_cnt != 2'd0) begin
        span = (grp_cnt > 2'd2) ? 2 : int'(grp_cnt);
        v = {grp_bits[15:0], 8'h00} << (8 * (2 - span));
        put_glyphs(v, span + 1);
      end
    end else begin
      if (c >= "A" && c <= "Z") begin
        sx = 6'(c - "A");
      end else if (c >= "a" && c <= "z") begin
        sx = 6'(c - "a" + 8'd26);
      end else if (c >= "0" && c <= "9") begin
        sx = 6'(c - "0" + 8'd52);
      end else if (c == "+") begin
        sx = 6'd62;
      end else if (c == "/") begin
        sx = 6'd63;
      end else begin
        known = 1'b0;
      end
      if (!is_pad && (!known || pad_cnt != 2'd0)) begin
        bad = 1'b1;
      end else if (grp_cnt == 2'd3) begin
        put_bytes({grp_bits, sx}, 4 - int'(pad_cnt) - int'(is_pad));
        clear_group();
      end else begin
        grp_bits = {grp_bits[11:0], sx};
        grp_cnt++;
        if (is_pad) pad_cnt++;
      end
      if (eom && grp_cnt != 2'd0) begin
        v = {grp_bits, 6'b000000} << (6 * (3 - int'(grp_cnt)));
        put_bytes(v, int'(grp_cnt) - int'(pad_cnt));
      end
    end
    if (eom) clear_group();
    if (item_beats.size() == 0 && (bad || eom)) add_beat(8'h00, 1'b0);
    for (k = 0; k < item_beats.size(); k++) begin
      b = item_beats[k];
      b.bad = bad;
      b.run_last = (k == item_beats.size() - 1);
      b.msg_last = eom && (k == item_beats.size() - 1);
      codec_beats_due.push_back(b);
    end
  endfunction

  function automatic void send(input logic [7:0] code, input logic eom);
    chars_to_send.push_back({code, eom});
  endfunction

  function automatic int queue_plain_message();
    int         len, k;
    logic [7:0] c;
    len = $urandom_range(7, 1);
    for (k = 0; k < len; k++) begin
      if (printable && $urandom_range(9) != 0) c = 8'($urandom_range(PrintableHi, PrintableLow));
      else c = 8'($urandom_range(255));
      send(c, (k == len - 1) && ($urandom_range(6) != 0));
    end
    return len;
  endfunction

  function automatic int queue_coded_message();
    int          len, nbytes, take, k, j;
    logic        keep_pad;
    logic [23:0] v;
    logic [7:0]  txt[$];
    if ($urandom_range(4) == 0) begin
      len = $urandom_range(8, 1);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(3))
          0: txt.push_back(8'($urandom_range(255)));
          1: txt.push_back(PadChar);
          default: txt.push_back(glyph(6'($urandom_range(63))));
        endcase
      end
    end else begin
      nbytes = $urandom_range(7, 1);
      keep_pad = ($urandom_range(3) != 0);
      for (k = 0; k < nbytes; k += 3) begin
        take = (nbytes - k > 3) ? 3 : nbytes - k;
        v = 24'($urandom);
        v = v & (24'hFFFFFF << (8 * (3 - take)));
        for (j = 0; j < 4; j++) begin
          if (j <= take) txt.push_back(glyph(v[23-6*j -: 6]));
          else if (keep_pad) txt.push_back(PadChar);
        end
      end
      if ($urandom_range(7) == 0) txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
    end
    for (k = 0; k < txt.size(); k++) begin
      send(txt[k], (k == txt.size() - 1) && ($urandom_range(9) != 0));
    end
    return txt.size();
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic settle();
    while (chars_to_send.size() != 0 || item_held || codec_beats_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin : drive_input
    item_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      item_held = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_codec_beats(in_if.data_char, in_if.message_end);
        items_in++;
        item_held = 1'b0;
      end
      if (!item_held) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = chars_to_send.pop_front();
          in_if.valid <= 1'b1;
          in_if.data_char <= nxt.code;
          in_if.message_end <= nxt.eom;
          item_held = 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    beat_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.out_char, out_if.char_valid, out_if.bad_input, out_if.run_last,
               out_if.message_last};
        results_seen++;
        if (codec_beats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("Unexpected result beat %0d: char %h valid %b bad %b run %b msg %b",
                     results_seen, got.ch, got.ch_ok, got.bad, got.run_last, got.msg_last);
          end
        end else begin
          want = codec_beats_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("Result beat %0d: expected char %h valid %b bad %b run %b msg %b,",
                       results_seen, want.ch, want.ch_ok, want.bad, want.run_last,
                       want.msg_last);
              $display("  got char %h valid %b bad %b run %b msg %b",
                       got.ch, got.ch_ok, got.bad, got.run_last, got.msg_last);
            end
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("Timeout: no beat moved for %0d cycles.", QuietLimit);
    $display("base64_stream_codec_core verification failed");
    $finish;
  end

  initial begin
    int n, ph;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_char = '0;
    in_if.message_end = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CfgMode, ModeEncode);
    write_reg(CfgPrintable, 1'b1);
    send("M", 1'b0);
    send("a", 1'b0);
    send("n", 1'b0);
    send(PrintableLow, 1'b0);
    send(PrintableHi, 1'b1);
    send(PrintableLow - 8'd1, 1'b0);
    send(PrintableHi + 8'd1, 1'b0);
    send("a", 1'b0);
    send(8'hFF, 1'b1);
    send(8'h00, 1'b1);
    settle();
    write_reg(CfgPrintable, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send("A", 1'b0);
    settle();
    // The held byte must be discarded by the mode change.
    write_reg(CfgMode, ModeDecode);
    send("/", 1'b0);
    send("/", 1'b0);
    send("R", 1'b0);
    send(PadChar, 1'b1);
    send("A", 1'b1);
    send("*", 1'b0);
    send("Q", 1'b0);
    send(PadChar, 1'b0);
    send("A", 1'b0);
    send(PadChar, 1'b1);

    for (ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
      endcase
      write_reg(CfgMode, ModeEncode);
      write_reg(CfgPrintable, 1'b1);
      n = 0;
      while (n < 7) n += queue_plain_message();
      settle();
      write_reg(CfgPrintable, 1'b0);
      n = 0;
      while (n < 7) n += queue_plain_message();
      settle();
      write_reg(CfgPrintable, 1'($urandom_range(1)));
      write_reg(CfgMode, ModeDecode);
      n = 0;
      while (n < 14) n += queue_coded_message();
      settle();
      write_reg(ph[0] ? CfgIdxMax : CfgPastEnd, 1'($urandom_range(1)));
    end
    settle();

    $display("Checked %0d result beats from %0d input beats in both modes,", results_seen,
             items_in);
    $display("with %0d register writes and four source and sink stall mixes.", reg_writes);
    if (mismatches == 0) begin
      $display("base64_stream_codec_core verification clean");
    end else begin
      $display("%0d result beats mismatched.", mismatches);
      $display("base64_stream_codec_core verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_ifs.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_fifo.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_stream_codec_core.sv
bench/tb.sv
